/* rtl/flm_pkg.sv */
// shared types and constants for the fifo queued lock manager
// no dependencies
`default_nettype none

package flm_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [15:0] NO_HOLDER = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_DESTROY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/flm_ctrl.sv */
// controller for the fifo queued lock manager: accept, execute, result strobe
// depends on flm_pkg
`default_nettype none

module flm_ctrl
	import flm_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

/* rtl/flm_dp.sv */
// datapath for the fifo queued lock manager: lock state, wait ring, result registers
// depends on flm_pkg
`default_nettype none

module flm_dp
	import flm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  cmd_t             cmd,
	input  wire  [1:0]       operation,
	input  wire  [7:0]       requester_machine,
	input  wire  [7:0]       requester_mailbox,
	input  wire              cfg_we,
	input  wire  [7:0]       cfg_data,
	output logic             grant_valid,
	output logic [7:0]       grant_machine,
	output logic [7:0]       grant_mailbox,
	output logic [7:0]       grant_lock,
	output logic             dropped_full,
	output logic             busy_now,
	output logic [CNT_W-1:0] waiting_count,
	output logic             destroy_pending
);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

	logic [15:0] mem [QUEUE_DEPTH];

	logic [1:0]       op_q;
	logic [15:0]      who_q;
	logic [7:0]       lock_number_q;
	logic             busy_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic             mark_q;
	logic [15:0]      rd_q;

	logic             busy_d;
	logic [PTR_W-1:0] head_d;
	logic [CNT_W-1:0] count_d;
	logic             mark_d;
	logic             grant_d;
	logic [15:0]      gid_d;
	logic             drop_d;
	logic             wr_en;
	logic [CNT_W:0]   tail_sum;
	logic [PTR_W-1:0] tail;

	// tail sits below twice the depth, one compare and subtract wraps it
	always_comb begin
		tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
		if (tail_sum >= DEPTH_SUM) begin
			tail = PTR_W'(tail_sum - DEPTH_SUM);
		end else begin
			tail = PTR_W'(tail_sum);
		end
	end

	always_comb begin
		busy_d  = busy_q;
		head_d  = head_q;
		count_d = count_q;
		mark_d  = mark_q;
		grant_d = 1'b0;
		gid_d   = NO_HOLDER;
		drop_d  = 1'b0;
		wr_en   = 1'b0;
		case (op_q)
			OP_ACQUIRE: begin
				if (count_q == '0 && !busy_q) begin
					busy_d  = 1'b1;
					grant_d = 1'b1;
					gid_d   = who_q;
				end else if (count_q >= DEPTH_CNT) begin
					drop_d = 1'b1;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_RELEASE: begin
				if (count_q != '0) begin
					grant_d = 1'b1;
					gid_d   = rd_q;
					busy_d  = 1'b1;
					count_d = count_q - 1'b1;
					head_d  = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
				end else begin
					busy_d = 1'b0;
				end
			end
			OP_DESTROY: begin
				if (busy_q) begin
					mark_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// ring storage, read data registered; head only moves at execute
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[tail] <= who_q;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			who_q <= {requester_machine, requester_mailbox};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_number_q   <= '0;
			busy_q          <= 1'b0;
			head_q          <= '0;
			count_q         <= '0;
			mark_q          <= 1'b0;
			grant_valid     <= 1'b0;
			grant_machine   <= '0;
			grant_mailbox   <= '0;
			grant_lock      <= '0;
			dropped_full    <= 1'b0;
			busy_now        <= 1'b0;
			waiting_count   <= '0;
			destroy_pending <= 1'b0;
		end else begin
			if (cfg_we) begin
				lock_number_q <= cfg_data;
			end
			if (cmd.exec) begin
				busy_q          <= busy_d;
				head_q          <= head_d;
				count_q         <= count_d;
				mark_q          <= mark_d;
				grant_valid     <= grant_d;
				grant_machine   <= grant_d ? gid_d[15:8] : 8'd0;
				grant_mailbox   <= grant_d ? gid_d[7:0] : 8'd0;
				grant_lock      <= grant_d ? lock_number_q : 8'd0;
				dropped_full    <= drop_d;
				busy_now        <= busy_d;
				waiting_count   <= count_d;
				destroy_pending <= mark_d;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/fifo_queued_lock_manager.sv */
// top level of the fifo queued lock manager
// depends on flm_pkg, flm_ctrl, flm_dp
`default_nettype none

// one mutex with a ring queue of waiting requesters (machine, mailbox).
// an item is taken at a clock edge with start high and busy low; it carries
// operation (acquire, release, destroy), requester_machine, requester_mailbox.
// busy rises for the one execute cycle that follows; each item gives exactly
// one result, on the result ports while done is high for one cycle, registered
// from the execute state. no new item is taken while busy is high, and
// the wait ring's read port is registered, so the head entry is fetched in
// the accept cycle and used in the execute cycle.
// the receiver cannot stall; a result not taken in its done cycle is overwritten by the next.
// cfg_we with cfg_data sets lock_number, carried in every grant; write it
// only while no item is in flight.
// reset clears the lock to free, the queue to empty, the destroy mark and
// lock_number; ring entries need no clearing since only written ones are read.
// an acquire on a full queue is dropped and flagged by dropped_full.

module fifo_queued_lock_manager
	import flm_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  wire  [1:0]       operation,
	input  wire  [7:0]       requester_machine,
	input  wire  [7:0]       requester_mailbox,
	input  wire              cfg_we,
	input  wire  [7:0]       cfg_data,
	output logic             done,
	output logic             grant_valid,
	output logic [7:0]       grant_machine,
	output logic [7:0]       grant_mailbox,
	output logic [7:0]       grant_lock,
	output logic             dropped_full,
	output logic             busy_now,
	output logic [CNT_W-1:0] waiting_count,
	output logic             destroy_pending
);

	cmd_t cmd;

	flm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	flm_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.operation         (operation),
		.requester_machine (requester_machine),
		.requester_mailbox (requester_mailbox),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.grant_valid       (grant_valid),
		.grant_machine     (grant_machine),
		.grant_mailbox     (grant_mailbox),
		.grant_lock        (grant_lock),
		.dropped_full      (dropped_full),
		.busy_now          (busy_now),
		.waiting_count     (waiting_count),
		.destroy_pending   (destroy_pending)
	);

endmodule

`default_nettype wire

/* bench/fifo_queued_lock_manager_test.sv */
// testbench for fifo_queued_lock_manager: directed and random lock traffic, checked against
// an in-bench prediction of the lock, its wait ring and the destroy mark
// depends on flm_pkg and fifo_queued_lock_manager
`default_nettype none

module fifo_queued_lock_manager_test;
	import flm_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic       grant_valid;
		logic [7:0] grant_machine;
		logic [7:0] grant_mailbox;
		logic [7:0] grant_lock;
		logic       dropped_full;
		logic       busy_now;
		logic [4:0] waiting_count;
		logic       destroy_pending;
	} lock_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] operation = OP_ACQUIRE;
	logic [7:0] requester_machine = 8'd0;
	logic [7:0] requester_mailbox = 8'd0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	wire       busy;
	wire       done;
	wire       grant_valid;
	wire [7:0] grant_machine;
	wire [7:0] grant_mailbox;
	wire [7:0] grant_lock;
	wire       dropped_full;
	wire       busy_now;
	wire [4:0] waiting_count;
	wire       destroy_pending;

	fifo_queued_lock_manager dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.requester_machine(requester_machine),
		.requester_mailbox(requester_mailbox),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.done             (done),
		.grant_valid      (grant_valid),
		.grant_machine    (grant_machine),
		.grant_mailbox    (grant_mailbox),
		.grant_lock       (grant_lock),
		.dropped_full     (dropped_full),
		.busy_now         (busy_now),
		.waiting_count    (waiting_count),
		.destroy_pending  (destroy_pending)
	);

	// predicted lock state
	logic        lock_held = 1'b0;
	logic [15:0] holder_id = NO_HOLDER;
	logic [15:0] wait_ring [DEPTH];
	int          ring_head = 0;
	int          ring_count = 0;
	logic        destroy_mark = 1'b0;
	logic [7:0]  lock_number = 8'd0;

	lock_result_t pending_results[$];
	int mismatches = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic lock_result_t apply_lock_request(input logic [1:0] op,
			input logic [7:0] machine, input logic [7:0] mailbox);
		lock_result_t r;
		logic [15:0] who;
		r = '0;
		who = {machine, mailbox};
		case (op)
			OP_ACQUIRE: begin
				if (ring_count == 0 && !lock_held) begin
					holder_id = who;
					lock_held = 1'b1;
					r.grant_valid = 1'b1;
					{r.grant_machine, r.grant_mailbox} = who;
				end else if (ring_count >= DEPTH) begin
					r.dropped_full = 1'b1;
				end else begin
					wait_ring[(ring_head + ring_count) % DEPTH] = who;
					ring_count++;
				end
			end
			OP_RELEASE: begin
				// no ownership check: any release drops the holder
				holder_id = NO_HOLDER;
				if (ring_count > 0) begin
					holder_id = wait_ring[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
					lock_held = 1'b1;
					r.grant_valid = 1'b1;
					{r.grant_machine, r.grant_mailbox} = holder_id;
				end else begin
					lock_held = 1'b0;
				end
			end
			OP_DESTROY: begin
				if (lock_held)
					destroy_mark = 1'b1;
			end
			default: ;
		endcase
		if (r.grant_valid)
			r.grant_lock = lock_number;
		r.busy_now = lock_held;
		r.waiting_count = 5'(ring_count);
		r.destroy_pending = destroy_mark;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (want !== got)
			flag_mismatch(what, want, got);
	endtask

	always @(posedge clk) begin
		lock_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing pending", 8'd0, 8'd1);
			end else begin
				want = pending_results.pop_front();
				check_field("grant_valid", 8'(want.grant_valid), 8'(grant_valid));
				check_field("grant_machine", want.grant_machine, grant_machine);
				check_field("grant_mailbox", want.grant_mailbox, grant_mailbox);
				check_field("grant_lock", want.grant_lock, grant_lock);
				check_field("dropped_full", 8'(want.dropped_full), 8'(dropped_full));
				check_field("busy_now", 8'(want.busy_now), 8'(busy_now));
				check_field("waiting_count", 8'(want.waiting_count), 8'(waiting_count));
				check_field("destroy_pending", 8'(want.destroy_pending),
					8'(destroy_pending));
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_request(input logic [1:0] op, input logic [7:0] machine,
			input logic [7:0] mailbox);
		start <= 1'b1;
		operation <= op;
		requester_machine <= machine;
		requester_mailbox <= mailbox;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_lock_request(op, machine, mailbox));
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_results.size() > 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_lock_number(input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		lock_number = value;
		@(negedge clk);
	endtask

	task automatic test_basic_ops();
		send_request(OP_RELEASE, 8'h00, 8'h00);   // release while free
		send_request(OP_DESTROY, 8'h12, 8'h34);   // destroy while free
		send_request(OP_UNUSED, 8'hFF, 8'hFF);
		send_request(OP_ACQUIRE, 8'h00, 8'h00);
		send_request(OP_ACQUIRE, 8'hFF, 8'hFF);
		send_request(OP_ACQUIRE, 8'hA5, 8'h5A);
		send_request(OP_RELEASE, 8'h77, 8'h77);   // release by a non-holder
		send_request(OP_DESTROY, 8'h01, 8'h80);   // sets the destroy mark
		send_request(OP_UNUSED, 8'h00, 8'h00);
		send_request(OP_RELEASE, 8'hA5, 8'h5A);
		send_request(OP_RELEASE, 8'h00, 8'h00);
	endtask

	task automatic test_full_queue();
		send_request(OP_ACQUIRE, 8'h01, 8'h01);
		for (int i = 0; i < DEPTH; i++)
			send_request(OP_ACQUIRE, 8'(i * 17), ~8'(i * 17));
		send_request(OP_ACQUIRE, 8'hFF, 8'h00);   // dropped, ring is full
		send_request(OP_RELEASE, 8'h01, 8'h01);
		send_request(OP_ACQUIRE, 8'h00, 8'hFF);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct);
		int acquire_pct;
		bit idle_on;
		int roll;
		logic [1:0] op;
		acquire_pct = 50;
		idle_on = 1'b0;
		for (int n = 0; n < count; n++) begin
			// bias shifts per burst so the ring swings between empty and full
			if (n % 32 == 0) begin
				case ($urandom_range(3))
					0: acquire_pct = 20;
					1: acquire_pct = 45;
					2: acquire_pct = 60;
					default: acquire_pct = 85;
				endcase
				idle_on = ($urandom_range(3) != 0);
			end
			roll = $urandom_range(99);
			if (roll < acquire_pct)
				op = OP_ACQUIRE;
			else if (roll < 95)
				op = OP_RELEASE;
			else if (roll < 98)
				op = OP_DESTROY;
			else
				op = OP_UNUSED;
			send_request(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
			if (idle_on && $urandom_range(99) < idle_pct)
				idle_sender($urandom_range(1, 4));
		end
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++)
			wait_ring[i] = 16'd0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_lock_number(8'h00);
		test_basic_ops();
		wait_for_results();

		write_lock_number(8'hFF);
		test_full_queue();
		wait_for_results();

		write_lock_number(8'h5C);
		test_random_traffic(300, 0);
		wait_for_results();

		write_lock_number(8'($urandom_range(255)));
		test_random_traffic(300, 48);
		wait_for_results();

		write_lock_number(8'h01);
		test_random_traffic(300, 37);
		wait_for_results();

		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
